// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the run queue checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wrrq_pkg.sv =====
// Types and constants of the weighted round-robin run queue.
package wrrq_pkg;

   localparam int MaxTasks = 16;
   localparam int TaskW    = 4;
   localparam int CountW   = 5;
   localparam int SliceW   = 8;
   localparam int KindW    = 3;
   localparam int ErrW     = 2;

   localparam logic [KindW-1:0] KindAdmit   = 3'd0;
   localparam logic [KindW-1:0] KindEnqueue = 3'd1;
   localparam logic [KindW-1:0] KindDequeue = 3'd2;
   localparam logic [KindW-1:0] KindTick    = 3'd3;
   localparam logic [KindW-1:0] KindYield   = 3'd4;

   localparam logic [ErrW-1:0] ErrNone   = 2'd0;
   localparam logic [ErrW-1:0] ErrQueued = 2'd1;
   localparam logic [ErrW-1:0] ErrAbsent = 2'd2;

   localparam logic CsrSliceFg = 1'b0;
   localparam logic CsrSliceBg = 1'b1;

   localparam logic [SliceW-1:0] SliceFgReset = 8'd10;
   localparam logic [SliceW-1:0] SliceBgReset = 8'd1;

   typedef struct packed {
      logic [KindW-1:0]  kind;
      logic [TaskW-1:0]  task_id;
      logic              is_background;
   } event_type;

   typedef struct packed {
      logic [ErrW-1:0]   error;
      logic [CountW-1:0] running_count;
      logic              need_resched;
      logic [TaskW-1:0]  head_task;
      logic              head_valid;
   } result_type;

   typedef struct packed {
      logic [SliceW-1:0] slice_background;
      logic [SliceW-1:0] slice_foreground;
   } slice_cfg_type;

   typedef struct packed {
      logic              en;
      logic [TaskW-1:0]  addr;
      logic [TaskW-1:0]  data;
   } link_wr_type;

endpackage

// ===== rtl/core/wrrq_in_stage.sv =====
// Input register of the run queue: holds one event until the core takes it.
module wrrq_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // task_id [3:0], is_background [4]
   input  logic [2:0]             req_tuser,   // kind [2:0]
   input  logic                   advance,
   output logic                   evt_valid,
   output wrrq_pkg::event_type    evt
);

   logic                valid_ff;
   wrrq_pkg::event_type evt_ff;

   // Take a new item when empty or when the held one moves on this cycle.
   assign req_tready = !valid_ff || advance;
   assign evt_valid  = valid_ff;
   assign evt        = evt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         evt_ff.kind          <= req_tuser;
         evt_ff.task_id       <= req_tdata[3:0];
         evt_ff.is_background <= req_tdata[4];
      end
   end

endmodule

// ===== rtl/core/wrrq_queue_core.sv =====
// Run queue state: per-task links, membership and slices; one event per cycle on step.
module wrrq_queue_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  wrrq_pkg::event_type        evt,
   input  wrrq_pkg::slice_cfg_type    cfg,
   output wrrq_pkg::result_type       result
);

   localparam int TaskW  = wrrq_pkg::TaskW;
   localparam int CountW = wrrq_pkg::CountW;
   localparam int SliceW = wrrq_pkg::SliceW;
   localparam int Depth  = wrrq_pkg::MaxTasks;

   logic [TaskW-1:0]  next_ff [Depth];
   logic [TaskW-1:0]  prev_ff [Depth];
   logic [SliceW-1:0] slice_ff [Depth];
   logic [Depth-1:0]  in_queue_ff;
   logic [TaskW-1:0]  head_ff, head_in;
   logic [TaskW-1:0]  tail_ff, tail_in;
   logic [CountW-1:0] count_ff, count_in;

   logic [TaskW-1:0]  t;
   logic [TaskW-1:0]  cur_next;
   logic [TaskW-1:0]  cur_prev;
   logic              inq;
   logic [SliceW-1:0] class_slice;
   logic [SliceW-1:0] slice_dec;
   logic              do_unlink;
   logic              do_append;
   logic [TaskW-1:0]  head_mid;
   logic [TaskW-1:0]  tail_mid;
   logic [CountW-1:0] count_mid;
   wrrq_pkg::link_wr_type next_wr_a, next_wr_b, prev_wr_a, prev_wr_b;
   logic              slice_we;
   logic [SliceW-1:0] slice_data;
   logic              resched;
   logic [wrrq_pkg::ErrW-1:0] err;

   assign t           = evt.task_id;
   assign cur_next    = next_ff[t];
   assign cur_prev    = prev_ff[t];
   assign inq         = in_queue_ff[t];
   assign class_slice = evt.is_background ? cfg.slice_background : cfg.slice_foreground;
   assign slice_dec   = slice_ff[t] - SliceW'(1);

   // Decode the event into unlink / append actions and slice writes.
   always_comb begin
      do_unlink  = 1'b0;
      do_append  = 1'b0;
      slice_we   = 1'b0;
      slice_data = class_slice;
      resched    = 1'b0;
      err        = wrrq_pkg::ErrNone;
      unique case (evt.kind)
         wrrq_pkg::KindAdmit: begin
            slice_we = 1'b1;
         end
         wrrq_pkg::KindEnqueue: begin
            if (inq) err = wrrq_pkg::ErrQueued;
            else     do_append = 1'b1;
         end
         wrrq_pkg::KindDequeue: begin
            if (!inq) err = wrrq_pkg::ErrAbsent;
            else      do_unlink = 1'b1;
         end
         wrrq_pkg::KindTick: begin
            slice_we = 1'b1;
            if (slice_dec == '0) begin
               if (inq && count_ff > CountW'(1)) begin
                  resched = 1'b1;
                  if (tail_ff != t) begin
                     do_unlink = 1'b1;
                     do_append = 1'b1;
                  end
               end
            end else begin
               slice_data = slice_dec;
            end
         end
         wrrq_pkg::KindYield: begin
            if (!inq) begin
               err = wrrq_pkg::ErrAbsent;
            end else if (count_ff > CountW'(1) && tail_ff != t) begin
               do_unlink = 1'b1;
               do_append = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Unlink first, then append against the list that unlink leaves.
   always_comb begin
      head_mid  = head_ff;
      tail_mid  = tail_ff;
      count_mid = count_ff;
      next_wr_a = '0;
      prev_wr_a = '0;
      if (do_unlink) begin
         if (head_ff == t) begin
            head_mid = cur_next;
         end else begin
            next_wr_a = '{en: 1'b1, addr: cur_prev, data: cur_next};
         end
         if (tail_ff == t) begin
            tail_mid = cur_prev;
         end else begin
            prev_wr_a = '{en: 1'b1, addr: cur_next, data: cur_prev};
         end
         count_mid = count_ff - CountW'(1);
      end
   end

   always_comb begin
      head_in   = head_mid;
      tail_in   = tail_mid;
      count_in  = count_mid;
      next_wr_b = '0;
      prev_wr_b = '0;
      if (do_append) begin
         if (count_mid == '0) begin
            head_in = t;
         end else begin
            next_wr_b = '{en: 1'b1, addr: tail_mid, data: t};
            prev_wr_b = '{en: 1'b1, addr: t, data: tail_mid};
         end
         tail_in  = t;
         count_in = count_mid + CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_queue_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else if (step) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         // A rotation unlinks and appends the same task: it stays queued.
         if (do_append)      in_queue_ff[t] <= 1'b1;
         else if (do_unlink) in_queue_ff[t] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < Depth; i++) begin
            if (next_wr_b.en && next_wr_b.addr == TaskW'(i)) next_ff[i] <= next_wr_b.data;
            else if (next_wr_a.en && next_wr_a.addr == TaskW'(i)) next_ff[i] <= next_wr_a.data;
            if (prev_wr_b.en && prev_wr_b.addr == TaskW'(i)) prev_ff[i] <= prev_wr_b.data;
            else if (prev_wr_a.en && prev_wr_a.addr == TaskW'(i)) prev_ff[i] <= prev_wr_a.data;
         end
         if (slice_we) slice_ff[t] <= slice_data;
      end
   end

   assign result.head_valid    = (count_in != '0);
   assign result.head_task     = (count_in != '0) ? head_in : '0;
   assign result.need_resched  = resched;
   assign result.running_count = count_in;
   assign result.error         = err;

endmodule

// ===== rtl/core/weighted_round_robin_run_queue.sv =====
// Weighted round-robin run queue: one event in, one queue snapshot out, per cycle
// unless rsp_tready stalls. Takes one event per clock when not stalled (admit, enqueue,
// dequeue, tick, yield) and answers each with one item showing the queue head, the
// queued count, need_resched and an error code; the result is registered as the event
// leaves the input stage. Per-task next and previous links, membership bits and slice
// counters live in flip-flop tables indexed by task id, so every event is a fixed set
// of table writes. A stall on rsp_tready holds both stages; the user must write slice
// registers through csr_* only while no event is in flight, unenforced by the block.
module weighted_round_robin_run_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // task_id [3:0], is_background [4], zero [7:5]
   input  logic [2:0]  req_tuser,   // kind [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // head_valid [0], head_task [4:1], need_resched [5],
                                    // running_count [10:6], error [12:11], zero [15:13]
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                       evt_valid;
   wrrq_pkg::event_type        evt;
   logic                       advance;
   logic                       step;
   wrrq_pkg::result_type       result;
   wrrq_pkg::slice_cfg_type    cfg_ff;
   logic                       rsp_valid_ff;
   wrrq_pkg::result_type       rsp_data_ff;

   // Move the pipeline whenever the result register is free or being drained.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign step    = evt_valid && advance;

   wrrq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   wrrq_queue_core u_queue_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .evt    (evt),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slice_foreground <= wrrq_pkg::SliceFgReset;
         cfg_ff.slice_background <= wrrq_pkg::SliceBgReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            wrrq_pkg::CsrSliceFg: cfg_ff.slice_foreground <= csr_wdata;
            wrrq_pkg::CsrSliceBg: cfg_ff.slice_background <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= evt_valid;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

// ===== rtl/core/wrrq_checker.sv =====
// Port-level checker for the run queue, bound to the top level.
`include "assert_macros.svh"

module wrrq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata
);

   localparam int CountW = wrrq_pkg::CountW;
   localparam int ErrW   = wrrq_pkg::ErrW;

   logic              stall;
   logic              hv;
   logic              rs;
   logic [CountW-1:0] cnt;
   logic [ErrW-1:0]   err;
   logic              range_ok;
   logic              resched_ok;

   assign stall      = rsp_tvalid && !rsp_tready;
   assign hv         = rsp_tdata[0];
   assign rs         = rsp_tdata[5];
   assign cnt        = rsp_tdata[10:6];
   assign err        = rsp_tdata[12:11];
   assign range_ok   = (cnt <= CountW'(wrrq_pkg::MaxTasks)) && (err <= wrrq_pkg::ErrAbsent);
   assign resched_ok = (err == wrrq_pkg::ErrNone) && (cnt >= CountW'(2));

   `ASSERT_NEXT(a_hold, clock, reset, stall, rsp_tvalid && $stable(rsp_tdata), "stall lost item")
   `ASSERT_IMPLIES(a_head, clock, reset, rsp_tvalid, hv == (cnt != '0), "bad head_valid")
   `ASSERT_IMPLIES(a_range, clock, reset, rsp_tvalid, range_ok, "count or error out of range")
   `ASSERT_IMPLIES(a_resched, clock, reset, rsp_tvalid && rs, resched_ok, "bad need_resched")

endmodule

bind weighted_round_robin_run_queue wrrq_checker u_wrrq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
